FILE: rtl/raoc_pkg.sv
package raoc_pkg;

  localparam int unsigned LevelW = 15;
  localparam int unsigned CountW = 32;
  localparam int unsigned DutyW  = 8;

  localparam logic [LevelW-1:0] OutMaxReset = 15'd25600;

  // floor(x / 100) == (x * 5243) >> 19 for x below 43699
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int unsigned RecipShift = 19;
  localparam logic [15:0] DivRoundUp = 16'd99;
  localparam logic [8:0]  DutyMax    = 9'd255;

  typedef enum logic [1:0] {
    CMD_STEP      = 2'd0,
    CMD_SETPOINT  = 2'd1,
    CMD_ENABLE    = 2'd2,
    CMD_INTERLOCK = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_OUT_MIN     = 2'd0,
    REG_OUT_MAX     = 2'd1,
    REG_RAMP_ENABLE = 2'd2,
    REG_RAMP_STEP   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DUTY_HOLD = 2'd0,
    DUTY_ZERO = 2'd1,
    DUTY_CALC = 2'd2
  } duty_mode_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] setpoint;
    logic        enable_value;
    logic [2:0]  interlock_bits;
    logic        tick_100ms;
    logic        tick_1s;
  } in_item_t;

  typedef struct packed {
    logic [DutyW-1:0]  pwm_duty;
    logic              report;
    logic              is_active;
    logic              is_interlocked;
    logic [CountW-1:0] starts;
    logic [CountW-1:0] active_tenths;
    logic [LevelW-1:0] level;
    logic [LevelW-1:0] average_level;
  } out_item_t;

  typedef struct packed {
    logic [LevelW-1:0] out_min;
    logic [LevelW-1:0] out_max;
    logic              ramp_enable;
    logic [LevelW-1:0] ramp_step;
  } cfg_t;

  // control stage -> filter stage
  typedef struct packed {
    logic              avg_upd;
    duty_mode_e        duty_mode;
    logic              report;
    logic              is_active;
    logic              is_interlocked;
    logic [CountW-1:0] starts;
    logic [CountW-1:0] active_tenths;
    logic [LevelW-1:0] level;
  } stage_t;

endpackage

FILE: rtl/raoc_in_if.sv
interface raoc_in_if import raoc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/raoc_out_if.sv
interface raoc_out_if import raoc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/raoc_step.sv
module raoc_step import raoc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output stage_t   entry_o
);

  logic [15:0]        target_q, target_d;
  logic               enabled_q, enabled_d;
  logic               locked_q, locked_d;
  logic               prev_en_q, prev_en_d;
  logic [LevelW-1:0]  level_q, level_d;
  logic [CountW-1:0]  tenths_q, tenths_d;
  logic [CountW-1:0]  starts_q, starts_d;

  logic signed [16:0] tgt_ext, max_ext, min_ext, tmin, clamp_s;
  logic [LevelW-1:0]  clamp, goal, ramped;
  logic [LevelW:0]    up_sum, goal_sum;

  // clamp to [min, max]; crossed limits give min
  assign tgt_ext = {target_q[15], target_q};
  assign max_ext = {2'b00, cfg_i.out_max};
  assign min_ext = {2'b00, cfg_i.out_min};
  assign tmin    = (tgt_ext < max_ext) ? tgt_ext : max_ext;
  assign clamp_s = (tmin < min_ext) ? min_ext : tmin;
  assign clamp   = clamp_s[LevelW-1:0];

  // ramp toward whole-percent goal
  assign goal     = {clamp[LevelW-1:8], 8'h00};
  assign up_sum   = {1'b0, level_q} + {1'b0, cfg_i.ramp_step};
  assign goal_sum = {1'b0, goal} + {1'b0, cfg_i.ramp_step};

  always_comb begin
    ramped = level_q;
    if (goal > level_q) begin
      ramped = (up_sum < {1'b0, goal}) ? up_sum[LevelW-1:0] : goal;
    end else if (goal < level_q) begin
      ramped = ({1'b0, level_q} > goal_sum) ? (level_q - cfg_i.ramp_step) : goal;
    end
  end

  always_comb begin
    target_d  = target_q;
    enabled_d = enabled_q;
    locked_d  = locked_q;
    prev_en_d = prev_en_q;
    level_d   = level_q;
    tenths_d  = tenths_q;
    starts_d  = starts_q;
    entry_o.avg_upd   = 1'b0;
    entry_o.duty_mode = DUTY_HOLD;
    entry_o.report    = item_i.tick_1s;

    case (item_i.cmd)
      CMD_SETPOINT: begin
        target_d = item_i.setpoint;
      end
      CMD_ENABLE: begin
        enabled_d = item_i.enable_value;
      end
      CMD_INTERLOCK: begin
        locked_d = |item_i.interlock_bits;
        if (|item_i.interlock_bits) begin
          enabled_d = 1'b0;
        end
      end
      CMD_STEP: begin
        if (enabled_q) begin
          if (!cfg_i.ramp_enable) begin
            level_d = clamp;
          end else if (item_i.tick_100ms) begin
            level_d = ramped;
          end
          if (item_i.tick_100ms) begin
            tenths_d        = tenths_q + 1'b1;
            entry_o.avg_upd = 1'b1;
          end
          entry_o.duty_mode = DUTY_CALC;
          if (!prev_en_q) begin
            starts_d       = starts_q + 1'b1;
            prev_en_d      = 1'b1;
            entry_o.report = 1'b1;
          end
        end else if (prev_en_q) begin
          prev_en_d         = 1'b0;
          level_d           = cfg_i.out_min;
          entry_o.duty_mode = DUTY_ZERO;
          entry_o.report    = 1'b1;
        end
      end
      default: ;
    endcase

    entry_o.is_active      = enabled_d;
    entry_o.is_interlocked = locked_d;
    entry_o.starts         = starts_d;
    entry_o.active_tenths  = tenths_d;
    entry_o.level          = level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      enabled_q <= 1'b0;
      locked_q  <= 1'b0;
      prev_en_q <= 1'b0;
      level_q   <= '0;
      tenths_q  <= '0;
      starts_q  <= '0;
    end else if (fire_i) begin
      target_q  <= target_d;
      enabled_q <= enabled_d;
      locked_q  <= locked_d;
      prev_en_q <= prev_en_d;
      level_q   <= level_d;
      tenths_q  <= tenths_d;
      starts_q  <= starts_d;
    end
  end

endmodule

FILE: rtl/raoc_filter.sv
module raoc_filter import raoc_pkg::*; (
  input  stage_t           entry_i,
  input  logic [DutyW-1:0] duty_prev_i,
  input  logic [LevelW-1:0] avg_prev_i,
  output out_item_t        item_o
);

  logic [LevelW+7:0]  lvl255;
  logic [LevelW-1:0]  duty_num;
  logic [27:0]        duty_prod;
  logic [8:0]         duty_quot;
  logic [DutyW-1:0]   duty;

  logic [15:0]        delta, mag;
  logic               neg;
  logic [28:0]        avg_prod;
  logic [9:0]         avg_quot;
  logic [LevelW-1:0]  avg_new;

  // duty = floor(floor(level * 255 / 256) / 100), saturated
  assign lvl255    = {entry_i.level, 8'h00} - {8'h00, entry_i.level};
  assign duty_num  = lvl255[LevelW+7:8];
  assign duty_prod = {13'd0, duty_num} * {15'd0, Recip100};
  assign duty_quot = duty_prod[RecipShift+8:RecipShift];
  assign duty      = (duty_quot > DutyMax) ? DutyMax[DutyW-1:0] : duty_quot[DutyW-1:0];

  // (99*avg + level)/100 == avg + floor((level - avg)/100)
  assign delta    = {1'b0, entry_i.level} - {1'b0, avg_prev_i};
  assign neg      = delta[15];
  assign mag      = neg ? ((~delta + 16'd1) + DivRoundUp) : delta;
  assign avg_prod = {13'd0, mag} * {16'd0, Recip100};
  assign avg_quot = avg_prod[RecipShift+9:RecipShift];
  assign avg_new  = neg ? (avg_prev_i - avg_quot[LevelW-1:0])
                        : (avg_prev_i + avg_quot[LevelW-1:0]);

  always_comb begin
    case (entry_i.duty_mode)
      DUTY_CALC: item_o.pwm_duty = duty;
      DUTY_ZERO: item_o.pwm_duty = '0;
      default:   item_o.pwm_duty = duty_prev_i;
    endcase
    item_o.report         = entry_i.report;
    item_o.is_active      = entry_i.is_active;
    item_o.is_interlocked = entry_i.is_interlocked;
    item_o.starts         = entry_i.starts;
    item_o.active_tenths  = entry_i.active_tenths;
    item_o.level          = entry_i.level;
    item_o.average_level  = entry_i.avg_upd ? avg_new : avg_prev_i;
  end

endmodule

FILE: rtl/ramped_analog_output_channel_top.sv
// Channel    | Dir | Handshake          | Payload
// -----------+-----+--------------------+------------------------------------
// req_i      | in  | valid/ready        | cmd, setpoint, enable_value, ...
// res_o      | out | valid/ready        | pwm_duty, report, counters, levels
// cfg_*      | in  | write enable only  | index 0..3, 15-bit data
//
// Two register stages: the control stage updates channel state the cycle a
// request is taken; the filter stage forms duty and running average (one
// constant-reciprocal multiply each) into the result register.
// Sustained rate one request per cycle while results drain; step results pass
// the middle and result registers. Setpoint, enable and interlock requests
// give no result. A held result does not stop intake while the middle stage
// is free. Reset is asynchronous: all state, counters and limits to defaults.
module ramped_analog_output_channel_top import raoc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  raoc_in_if.sink           req_i,
  raoc_out_if.source        res_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [LevelW-1:0] cfg_wdata_i
);

  cfg_t      cfg_q;
  stage_t    entry;
  stage_t    mid_q;
  logic      mid_valid_q;
  out_item_t res_d, res_q;
  logic      res_valid_q;
  logic      advance, take;

  // result register moves when empty or being drained
  assign advance     = !res_valid_q || res_o.ready;
  assign req_i.ready = !mid_valid_q || advance;
  assign take        = req_i.valid && req_i.ready;

  // configuration, to be written only while idle; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_min     <= '0;
      cfg_q.out_max     <= OutMaxReset;
      cfg_q.ramp_enable <= 1'b0;
      cfg_q.ramp_step   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_OUT_MIN:     cfg_q.out_min     <= cfg_wdata_i;
        REG_OUT_MAX:     cfg_q.out_max     <= cfg_wdata_i;
        REG_RAMP_ENABLE: cfg_q.ramp_enable <= cfg_wdata_i[0];
        REG_RAMP_STEP:   cfg_q.ramp_step   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  raoc_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (take),
    .item_i  (req_i.payload),
    .cfg_i   (cfg_q),
    .entry_o (entry)
  );

  // middle stage: only step requests carry a result forward
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (take) begin
      mid_valid_q <= (req_i.payload.cmd == CMD_STEP);
    end else if (advance) begin
      mid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mid_q <= entry;
    end
  end

  // last duty and running average live in the result register itself
  raoc_filter u_filter (
    .entry_i     (mid_q),
    .duty_prev_i (res_q.pwm_duty),
    .avg_prev_i  (res_q.average_level),
    .item_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else if (advance) begin
      res_valid_q <= mid_valid_q;
      if (mid_valid_q) begin
        res_q <= res_d;
      end
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

endmodule

FILE: rtl/raoc_checker.sv
module raoc_checker import raoc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      res_valid,
  input logic      res_ready,
  input out_item_t res_item
);

  // a held result keeps its valid and contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) !rst_ni |-> !res_valid)
    else $error("result valid during reset");

  // a disabled channel drives no duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_item.is_active |-> res_item.pwm_duty == '0)
    else $error("duty nonzero while disabled");

  // full scale level saturates the duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_item.is_active && (res_item.level >= OutMaxReset)
    |-> res_item.pwm_duty == DutyMax[DutyW-1:0])
    else $error("duty not at full scale");

endmodule

bind ramped_analog_output_channel_top raoc_checker u_raoc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_item  (res_o.payload)
);
